/* src/lcd_controller_spi_frame_writer_macros.svh */
// Assertion helpers for the frame writer; clk and rst must be in scope.
`ifndef LCD_CONTROLLER_SPI_FRAME_WRITER_MACROS_SVH
`define LCD_CONTROLLER_SPI_FRAME_WRITER_MACROS_SVH

// same-cycle implication
`define LCDW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LCDW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/lcdw_pkg.sv */
package lcdw_pkg;

  localparam logic [2:0] CMD_SERIAL = 3'd0;
  localparam logic [2:0] CMD_SELECT = 3'd1;
  localparam logic [2:0] CMD_MODE   = 3'd2;
  localparam logic [2:0] CMD_RESET  = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  localparam logic [7:0] BYTE_CLEAR  = 8'hE2;
  localparam logic [7:0] MASK_START  = 8'b1100_0000;
  localparam logic [7:0] PAT_START   = 8'b0100_0000;
  localparam logic [7:0] MASK_NIBBLE = 8'b1111_0000;
  localparam logic [7:0] PAT_PAGE    = 8'b1011_0000;
  localparam logic [7:0] PAT_COL_HI  = 8'b0001_0000;
  localparam logic [7:0] PAT_COL_LO  = 8'b0000_0000;
  localparam logic [4:0] START_MASK  = 5'b11111;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_START,
    OP_PAGE,
    OP_COL_HI,
    OP_COL_LO,
    OP_WRITE,
    OP_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
    logic [3:0] rpage;
    logic [7:0] rcol;
  } op_t;

endpackage

/* src/lcdw_front.sv */
module lcdw_front #(
  parameter int PAGES   = 8,
  parameter int COLUMNS = 128
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [23:0]    s_tdata,   // value[7:0], read_page[11:8], read_column[19:12]
  input  logic [2:0]     s_tuser,   // command[2:0]
  input  logic           q_full,
  input  logic           clearing,
  output logic           q_push,
  output lcdw_pkg::op_t  q_op
);
  import lcdw_pkg::*;

  logic       select_level;
  logic       data_mode;
  logic [7:0] value;
  logic [3:0] rpage;
  logic [7:0] rcol;
  logic       level;
  logic       read_ok;
  op_kind_t   kind;
  op_kind_t   byte_kind;

  assign value   = s_tdata[7:0];
  assign rpage   = s_tdata[11:8];
  assign rcol    = s_tdata[19:12];
  assign level   = (value != 8'd0);
  assign read_ok = ({1'b0, rpage} < 5'(PAGES)) && ({1'b0, rcol} < 9'(COLUMNS));

  assign s_tready = !q_full && !clearing;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    if (value == BYTE_CLEAR) begin
      byte_kind = OP_CLEAR;
    end else if ((value & MASK_START) == PAT_START) begin
      byte_kind = OP_START;
    end else if ((value & MASK_NIBBLE) == PAT_PAGE) begin
      byte_kind = OP_PAGE;
    end else if ((value & MASK_NIBBLE) == PAT_COL_HI) begin
      byte_kind = OP_COL_HI;
    end else if ((value & MASK_NIBBLE) == PAT_COL_LO) begin
      byte_kind = OP_COL_LO;
    end else begin
      byte_kind = OP_NONE;
    end
  end

  always_comb begin
    kind = OP_NONE;
    case (s_tuser)
      CMD_SERIAL: begin
        if (select_level) begin
          kind = data_mode ? OP_WRITE : byte_kind;
        end
      end
      CMD_RESET: begin
        kind = level ? OP_NONE : OP_CLEAR;
      end
      CMD_READ: begin
        kind = read_ok ? OP_READ : OP_NONE;
      end
      default: begin
        kind = OP_NONE;
      end
    endcase
  end

  assign q_op = '{kind: kind, data: value, rpage: rpage, rcol: rcol};

  always_ff @(posedge clk) begin
    if (rst) begin
      select_level <= 1'b0;
      data_mode    <= 1'b0;
    end else if (q_push) begin
      if (s_tuser == CMD_SELECT) begin
        select_level <= level;
      end
      if (s_tuser == CMD_MODE) begin
        data_mode <= level;
      end
    end
  end

endmodule

/* src/lcdw_fifo.sv */
module lcdw_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lcdw_pkg::op_t  push_op,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output lcdw_pkg::op_t  head
);
  import lcdw_pkg::*;

  op_t        entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* src/lcdw_back.sv */
module lcdw_back #(
  parameter int PAGES   = 8,
  parameter int COLUMNS = 128
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  lcdw_pkg::op_t  q_op,
  output logic           q_pop,
  output logic           clearing,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [31:0]    m_tdata
);
  import lcdw_pkg::*;

  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int AW     = PAGE_W + COL_W;
  localparam int DEPTH  = 1 << AW;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CLEAR = 4'b0010,
    ST_READ  = 4'b0100,
    ST_WRITE = 4'b1000
  } state_t;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    mem_rdata;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_wdata;

  state_t        state, state_next;
  logic [3:0]    page_address, page_next;
  logic [7:0]    column_address, column_next;
  logic [4:0]    start_line_value, start_next;
  logic [AW-1:0] clr_addr, clr_next;
  logic [7:0]    wbyte, wbyte_next;
  logic [31:0]   out_word;
  logic          out_free;
  logic          emit;
  logic [7:0]    emit_rdata;
  logic          write_ok;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] rd_addr;

  assign out_free = !m_tvalid || m_tready;
  assign clearing = (state == ST_CLEAR);
  assign write_ok = ({1'b0, page_address} < 5'(PAGES)) &&
                    ({1'b0, column_address} < 9'(COLUMNS));
  assign cur_addr = {page_address[PAGE_W-1:0], column_address[COL_W-1:0]};
  assign rd_addr  = {q_op.rpage[PAGE_W-1:0], q_op.rcol[COL_W-1:0]};
  assign m_tdata  = out_word;

  always_comb begin
    state_next  = state;
    page_next   = page_address;
    column_next = column_address;
    start_next  = start_line_value;
    clr_next    = clr_addr;
    wbyte_next  = wbyte;
    q_pop       = 1'b0;
    emit        = 1'b0;
    emit_rdata  = 8'd0;
    mem_we      = 1'b0;
    mem_waddr   = cur_addr;
    mem_wdata   = 8'd0;
    mem_re      = 1'b0;
    mem_raddr   = cur_addr;
    case (state)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          emit  = 1'b1;
          case (q_op.kind)
            OP_CLEAR: begin
              state_next = ST_CLEAR;
              clr_next   = '0;
            end
            OP_START: begin
              start_next = q_op.data[4:0] & START_MASK;
            end
            OP_PAGE: begin
              page_next = q_op.data[3:0];
            end
            OP_COL_HI: begin
              column_next = {q_op.data[3:0], column_address[3:0]};
            end
            OP_COL_LO: begin
              column_next = {column_address[7:4], q_op.data[3:0]};
            end
            OP_WRITE: begin
              if (write_ok) begin
                emit       = 1'b0;
                mem_re     = 1'b1;
                wbyte_next = q_op.data;
                state_next = ST_WRITE;
              end else begin
                column_next = column_address + 8'd1;
              end
            end
            OP_READ: begin
              emit       = 1'b0;
              mem_re     = 1'b1;
              mem_raddr  = rd_addr;
              state_next = ST_READ;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        clr_next  = clr_addr + 1'b1;
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_rdata = mem_rdata;
          state_next = ST_IDLE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          mem_we      = 1'b1;
          mem_wdata   = mem_rdata | wbyte;
          column_next = column_address + 8'd1;
          emit        = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      clr_addr         <= '0;
      page_address     <= 4'd0;
      column_address   <= 8'd0;
      start_line_value <= 5'd0;
      m_tvalid         <= 1'b0;
    end else begin
      state            <= state_next;
      clr_addr         <= clr_next;
      page_address     <= page_next;
      column_address   <= column_next;
      start_line_value <= start_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wbyte <= wbyte_next;
    if (emit) begin
      out_word <= {7'd0, column_next, page_next, start_next, emit_rdata};
    end
  end

endmodule

/* src/lcd_controller_spi_frame_writer.sv */
// Page-organized monochrome LCD frame writer.
// Input words (s_*): tuser carries the command (serial byte, chip select,
// data/command, reset line, read); tdata carries the byte or line level and
// the page/column of a read-back. Every accepted word gives exactly one
// output word (m_*) with the read-back byte (zero unless a read inside the
// display) and the start line, page and column after the word took effect.
// Path: register commands go from the queue to the output register; a data byte
// or a read inside the display first takes one registered memory read.
// Register commands are taken one word per cycle while m_tready is high; the next
// word waits while a memory word does its read or read-modify-write of the frame memory.
// A clear (command 0xE2 or reset line driven low) sweeps the frame memory one
// byte per cycle, all 2**(PAGE_W+COL_W) bytes (1024 by default), with s_tready low.
// After rst the same sweep runs before the first word
// is taken. A two-entry queue separates decode from execution; when m_tready
// is low the output word holds and input is taken until the queue fills.
module lcd_controller_spi_frame_writer #(
  parameter int PAGES   = 8,
  parameter int COLUMNS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // value[7:0], read_page[11:8], read_column[19:12]
  input  logic [2:0]  s_tuser,   // command[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // read_data[7:0], start_line[12:8], page[16:13],
                                 // column[24:17]
);
  import lcdw_pkg::*;

  op_t  push_op;
  op_t  head_op;
  logic push;
  logic pop;
  logic full;
  logic q_valid;
  logic clearing;

  lcdw_front #(
    .PAGES   (PAGES),
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (full),
    .clearing (clearing),
    .q_push   (push),
    .q_op     (push_op)
  );

  lcdw_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (full),
    .pop     (pop),
    .valid   (q_valid),
    .head    (head_op)
  );

  lcdw_back #(
    .PAGES   (PAGES),
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_op     (head_op),
    .q_pop    (pop),
    .clearing (clearing),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* src/lcdw_checker.sv */
`include "lcd_controller_spi_frame_writer_macros.svh"

module lcdw_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  logic [2:0] outstanding;
  logic       s_fire;
  logic       m_fire;

  assign s_fire = s_tvalid && s_tready;
  assign m_fire = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= 3'd0;
    end else if (s_fire && !m_fire) begin
      outstanding <= outstanding + 3'd1;
    end else if (m_fire && !s_fire) begin
      outstanding <= outstanding - 3'd1;
    end
  end

  // stalled output word holds
  `LCDW_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed under stall")
  // no word delivered without one taken in
  `LCDW_ASSERT_IMP(a_no_extra, m_fire, outstanding != 3'd0, "output word without input word")
  // queue plus execution plus output register bound what is in flight
  `LCDW_ASSERT_IMP(a_capacity, 1'b1, outstanding <= 3'd4, "too many words in flight")
  // memory sweep after reset blocks input
  `LCDW_ASSERT_IMP(a_reset_sweep, $fell(rst), !s_tready, "input taken during reset clear")

endmodule

bind lcd_controller_spi_frame_writer lcdw_checker u_checker (.*);

/* sim/tb_top.sv */
module tb_top;
  import lcdw_pkg::*;

  localparam int NUM_PAGES   = 8;
  localparam int NUM_COLS    = 128;
  localparam int STALL_LIMIT = 6000;
  localparam int HOLD_CYCLES = 300;

  localparam logic [2:0] CMD_SPARE5 = 3'd5;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] value;
    logic [3:0] rpage;
    logic [7:0] rcol;
  } lcd_word_t;

  typedef struct packed {
    logic [7:0] rd;
    logic [4:0] sl;
    logic [3:0] pg;
    logic [7:0] col;
  } lcd_status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  lcd_word_t   frame_words_q[$];
  lcd_status_t frame_status_q[$];
  lcd_word_t   offered_word;
  lcd_status_t seen_status, want_status;

  // shadow of the display controller
  logic [7:0] fb_mem [0:NUM_PAGES*NUM_COLS-1];
  logic       cs_level = 1'b0;
  logic       dc_level = 1'b0;
  logic [3:0] cur_page = '0;
  logic [7:0] cur_col = '0;
  logic [4:0] cur_start = '0;

  int  words_in = 0;
  int  words_out = 0;
  int  bad_words = 0;
  int  stall_cycles = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  send_gap;
  int  stim_words = 0;

  always #5 clk = ~clk;

  lcd_controller_spi_frame_writer #(
    .PAGES  (NUM_PAGES),
    .COLUMNS(NUM_COLS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  function automatic void wipe_frame();
    for (int i = 0; i < NUM_PAGES * NUM_COLS; i++) fb_mem[i] = 8'h00;
  endfunction

  function automatic lcd_status_t apply_word(lcd_word_t w);
    lcd_status_t st;
    logic        lvl;
    lvl = (w.value != 8'h00);
    st.rd = 8'h00;
    case (w.cmd)
      CMD_SERIAL: begin
        if (cs_level && dc_level) begin
          if (cur_page < NUM_PAGES && cur_col < NUM_COLS)
            fb_mem[int'(cur_page) * NUM_COLS + int'(cur_col)] |= w.value;
          cur_col = cur_col + 8'd1;
        end else if (cs_level) begin
          if (w.value == BYTE_CLEAR) wipe_frame();
          else if ((w.value & MASK_START) == PAT_START) cur_start = w.value[4:0] & START_MASK;
          else if ((w.value & MASK_NIBBLE) == PAT_PAGE) cur_page = w.value[3:0];
          else if ((w.value & MASK_NIBBLE) == PAT_COL_HI) cur_col[7:4] = w.value[3:0];
          else if ((w.value & MASK_NIBBLE) == PAT_COL_LO) cur_col[3:0] = w.value[3:0];
        end
      end
      CMD_SELECT: cs_level = lvl;
      CMD_MODE:   dc_level = lvl;
      CMD_RESET:  if (!lvl) wipe_frame();
      CMD_READ: begin
        if (w.rpage < NUM_PAGES && w.rcol < NUM_COLS)
          st.rd = fb_mem[int'(w.rpage) * NUM_COLS + int'(w.rcol)];
      end
      default: ;
    endcase
    st.sl  = cur_start;
    st.pg  = cur_page;
    st.col = cur_col;
    return st;
  endfunction

  task automatic push_word(logic [2:0] cmd, logic [7:0] val);
    lcd_word_t w;
    w.cmd   = cmd;
    w.value = val;
    w.rpage = 4'($urandom);
    w.rcol  = 8'($urandom);
    frame_words_q.push_back(w);
    if (cmd <= CMD_READ) stim_words++;
  endtask

  task automatic read_word(logic [3:0] rp, logic [7:0] rc);
    lcd_word_t w;
    w.cmd   = CMD_READ;
    w.value = 8'($urandom);
    w.rpage = rp;
    w.rcol  = rc;
    frame_words_q.push_back(w);
    stim_words++;
  endtask

  // select, address setup, a run of pixel bytes, then read-backs of the run
  task automatic add_burst();
    logic [3:0] pg;
    logic [7:0] col;
    int         n;
    pg = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 8)) : 4'($urandom_range(7));
    case ($urandom_range(3))
      0:       col = 8'($urandom_range(255));
      1:       col = 8'($urandom_range(135, 120));
      2:       col = 8'($urandom_range(255, 250));
      default: col = 8'($urandom_range(15));
    endcase
    n = $urandom_range(8, 1);
    push_word(CMD_SELECT, 8'($urandom_range(255, 1)));
    push_word(CMD_MODE, 8'h00);
    if ($urandom_range(3) == 0) push_word(CMD_SERIAL, PAT_START | 8'($urandom_range(63)));
    push_word(CMD_SERIAL, PAT_PAGE | {4'h0, pg});
    push_word(CMD_SERIAL, PAT_COL_HI | {4'h0, col[7:4]});
    push_word(CMD_SERIAL, PAT_COL_LO | {4'h0, col[3:0]});
    push_word(CMD_MODE, 8'($urandom_range(255, 1)));
    repeat (n) push_word(CMD_SERIAL, 8'($urandom));
    repeat ($urandom_range(4, 1)) read_word(pg, col + 8'($urandom_range(n - 1)));
  endtask

  task automatic add_noise();
    repeat ($urandom_range(6, 1)) begin
      case ($urandom_range(5))
        0:       push_word(3'($urandom_range(7)), 8'($urandom));
        1:       read_word(4'($urandom), 8'($urandom));
        2:       push_word(CMD_SELECT, ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom));
        3:       push_word(CMD_MODE, ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom));
        4:       push_word(CMD_RESET, 8'($urandom_range(255, 1)));
        default: push_word(CMD_SERIAL, 8'($urandom));
      endcase
    end
    if ($urandom_range(19) == 0) push_word(CMD_RESET, 8'h00);
  endtask

  initial begin
    wipe_frame();

    read_word(4'd0, 8'd0);
    push_word(CMD_SERIAL, BYTE_CLEAR);             // chip select low: ignored
    push_word(CMD_SELECT, 8'h80);
    push_word(CMD_MODE, 8'h00);
    push_word(CMD_SERIAL, PAT_START | 8'h3F);
    push_word(CMD_SERIAL, PAT_PAGE | 8'h07);
    push_word(CMD_SERIAL, PAT_COL_HI | 8'h0F);
    push_word(CMD_SERIAL, PAT_COL_LO | 8'h0F);
    push_word(CMD_SERIAL, 8'hFF);                  // no matching pattern
    push_word(CMD_MODE, 8'hFF);
    push_word(CMD_SERIAL, 8'hFF);                  // column 255: dropped, wraps
    push_word(CMD_SERIAL, 8'hA5);
    push_word(CMD_SERIAL, 8'h5A);
    read_word(4'd7, 8'd0);
    read_word(4'd15, 8'd255);
    read_word(4'd8, 8'd0);
    read_word(4'd0, 8'd128);
    push_word(CMD_MODE, 8'h00);
    push_word(CMD_SERIAL, PAT_PAGE | 8'h0F);
    push_word(CMD_MODE, 8'h01);
    push_word(CMD_SERIAL, 8'h3C);                  // page 15: dropped
    push_word(CMD_SPARE5, 8'hFF);
    push_word(CMD_SPARE6, 8'h00);
    push_word(CMD_SPARE7, 8'h55);
    push_word(CMD_RESET, 8'h01);
    push_word(CMD_RESET, 8'h00);
    read_word(4'd7, 8'd1);

    while (stim_words < 600) begin
      if ($urandom_range(3) == 0) add_noise();
      else add_burst();
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (frame_words_q.size() != 0 || s_tvalid) @(posedge clk);
    while (frame_status_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (bad_words == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        frame_status_q.push_back(apply_word(offered_word));
        words_in <= words_in + 1;
      end
      if (!s_tvalid || s_tready) begin
        send_gap = ($urandom_range(99) < 27) && !(words_in >= 350 && words_in < 450)
                   && hold_left == 0;
        if (frame_words_q.size() != 0 && !send_gap) begin
          offered_word = frame_words_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {4'h0, offered_word.rcol, offered_word.rpage, offered_word.value};
          s_tuser  <= offered_word.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off so the input side backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && words_out >= 150) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (hold_left == 0) &&
                  (($urandom_range(99) >= 27) || (words_out >= 350 && words_out < 450));
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_status.rd  = m_tdata[7:0];
      seen_status.sl  = m_tdata[12:8];
      seen_status.pg  = m_tdata[16:13];
      seen_status.col = m_tdata[24:17];
      words_out <= words_out + 1;
      if (frame_status_q.size() == 0) begin
        if (bad_words < 10) $display("unexpected output word %h", m_tdata);
        bad_words++;
      end else begin
        want_status = frame_status_q.pop_front();
        if (seen_status != want_status) begin
          if (bad_words < 10)
            $display("word %0d: exp rd=%h sl=%h pg=%h col=%h got rd=%h sl=%h pg=%h col=%h",
                     words_out, want_status.rd, want_status.sl, want_status.pg,
                     want_status.col, seen_status.rd, seen_status.sl, seen_status.pg,
                     seen_status.col);
          bad_words++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

endmodule
